// ----- design/grsc_pkg.sv -----
// types, constants and the sine table generator for the gimbal roll sine commutation unit
// holds the microcode program shared by the sequencer; no dependencies
`default_nettype none

package grsc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_DRIVE_POWER      = 2'd0;
  localparam logic [1:0] REG_ROTATION_FORWARD = 2'd1;
  localparam logic [1:0] REG_STEP_SCALE       = 2'd2;

  // register reset values
  localparam logic [7:0]  DRIVE_POWER_RESET = 8'd50;
  localparam logic        ROTATION_RESET    = 1'b1;
  localparam logic [15:0] STEP_SCALE_RESET  = 16'd1049;

  // angle constants in binary angle units
  localparam logic [16:0] QUARTER_TURN   = 17'd16384;
  localparam logic [16:0] ONE_DEGREE     = 17'd182;
  localparam logic [15:0] THIRD_TURN     = 16'd21845;
  localparam logic [15:0] TWO_THIRD_TURN = 16'd43691;

  // percent clamp and command saturation
  localparam logic [7:0]  FULL_POWER  = 8'd100;
  localparam logic [13:0] COMMAND_SAT = 14'd16383;

  // divide by 100 as multiply by ceil(2^30/100), exact for dividends below 2^23
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sequencer steps
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_ROLL    = 4'd1;
  localparam step_t STEP_ABS     = 4'd2;
  localparam step_t STEP_STEPMUL = 4'd3;
  localparam step_t STEP_UPDATE  = 4'd4;
  localparam step_t STEP_LOOKUP  = 4'd5;
  localparam step_t STEP_MULA    = 4'd6;
  localparam step_t STEP_MULB    = 4'd7;
  localparam step_t STEP_STORE   = 4'd8;
  localparam step_t STEP_OUTPUT  = 4'd9;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ROLL,
    OP_ABS,
    OP_STEPMUL,
    OP_UPDATE,
    OP_LOOKUP,
    OP_MULA,
    OP_MULB,
    OP_STORE,
    OP_OUTPUT
  } op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_LOOP,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    op_t   op;
    jmp_t  jmp;
    step_t target;
  } uword_t;

  // control store
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      STEP_IDLE:    w = '{op: OP_IDLE,    jmp: JMP_WAIT_IN,  target: STEP_IDLE};
      STEP_ROLL:    w = '{op: OP_ROLL,    jmp: JMP_NEXT,     target: STEP_IDLE};
      STEP_ABS:     w = '{op: OP_ABS,     jmp: JMP_NEXT,     target: STEP_IDLE};
      STEP_STEPMUL: w = '{op: OP_STEPMUL, jmp: JMP_NEXT,     target: STEP_IDLE};
      STEP_UPDATE:  w = '{op: OP_UPDATE,  jmp: JMP_NEXT,     target: STEP_IDLE};
      STEP_LOOKUP:  w = '{op: OP_LOOKUP,  jmp: JMP_NEXT,     target: STEP_IDLE};
      STEP_MULA:    w = '{op: OP_MULA,    jmp: JMP_NEXT,     target: STEP_IDLE};
      STEP_MULB:    w = '{op: OP_MULB,    jmp: JMP_NEXT,     target: STEP_IDLE};
      STEP_STORE:   w = '{op: OP_STORE,   jmp: JMP_LOOP,     target: STEP_LOOKUP};
      STEP_OUTPUT:  w = '{op: OP_OUTPUT,  jmp: JMP_WAIT_OUT, target: STEP_IDLE};
      default:      w = '{op: OP_IDLE,    jmp: JMP_WAIT_OUT, target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // q15 sine at a binary angle, taylor series over the first quadrant
  // evaluated at elaboration to fill the table
  function automatic logic signed [15:0] exact_sine(input logic [15:0] bam);
    logic [1:0]         quad;
    logic [63:0]        f;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q15;
    logic [15:0]        mag;
    quad = bam[15:14];
    f    = {50'd0, bam[13:0]};
    if (quad[0]) begin
      f = 64'd16384 - f;
    end
    x    = (f * HALF_PI_Q30) >> 14;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q15 = (unsigned'(sum) + 64'd16384) >> 15;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    mag = q15[15:0];
    return quad[1] ? -signed'(mag) : signed'(mag);
  endfunction

endpackage

`default_nettype wire

// ----- design/gimbal_roll_sine_commutation_unit.sv -----
// top level of the gimbal roll sine commutation unit: microcoded sequencer and datapath
// depends on grsc_pkg for the control store, codes and the sine generator
`default_nettype none

// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    roll_angle, signed binary angle
// m_*       out  m_tvalid / m_tready    phase_a, phase_b, phase_c pwm commands
// cfg_*     in   cfg_valid / cfg_ready  register index and write data
//
// one roll sample goes from its transfer to a valid result through four steps of
// speed and step math, then the shared lookup / two multiplies / store loop runs once per
// phase on the single sine rom read port and the one shared multiplier path
// rst is synchronous: registers back to defaults, angle and counter cleared
// the result sits in an output register, so the next sample is taken while it waits;
// the sequencer stalls in its last step only if a previous result is still untaken

module gimbal_roll_sine_commutation_unit #(
  parameter int unsigned MAX_COMMAND      = 9600,
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // roll sample in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] roll_angle
  // commands out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [13:0] phase_a, [27:14] phase_b, [41:28] phase_c,
                                      // [47:42] zero
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import grsc_pkg::*;

  localparam int unsigned IW = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
  localparam int unsigned PW = 16 + $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned MW = $clog2(MAX_COMMAND + 1);
  localparam int unsigned KW = MW + 7;       // max_command times clamped percent
  localparam int unsigned NW = KW + 16;      // times offset sine
  localparam int unsigned QW = KW + 24;      // quotient by 65536 times reciprocal of 100

  // configuration registers
  logic [7:0]  drive_power;
  logic        rotation_forward;
  logic [15:0] step_scale;

  // sequencer
  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic [1:0] ph;

  // state and datapath
  logic [15:0]        roll;
  logic [15:0]        ea;
  logic [2:0]         pc;
  logic               neg;
  logic               big;
  logic               move;
  logic [14:0]        s;
  logic [31:0]        prod;
  logic [KW-1:0]      k;
  logic [NW-1:0]      num;
  logic [QW-1:0]      quo;
  logic [13:0]        cmd_a;
  logic [13:0]        cmd_b;
  logic [13:0]        cmd_c;
  logic signed [15:0] sin_q;

  // sine rom built at elaboration
  logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];
  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    assign sine_rom[i] = exact_sine(16'((i * 65536) / SINE_TABLE_DEPTH));
  end

  logic [15:0]    rom_bam;
  logic [PW-1:0]  rom_prod;
  logic [IW-1:0]  rom_idx;
  logic [15:0]    phase_off;
  logic [16:0]    mag;
  logic [6:0]     pct;
  logic [16:0]    three_s;
  logic [2:0]     speed;
  logic [2:0]     period;
  logic [2:0]     pc_inc;
  logic [15:0]    step_amt;
  logic           add;
  logic [QW-1:0]  cmd_full;
  logic [13:0]    cmd_sat;
  logic           out_free;
  logic           in_xfer;

  assign uw        = ucode(step);
  assign cfg_ready = 1'b1;
  assign s_tready  = (uw.op == OP_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_power      <= DRIVE_POWER_RESET;
      rotation_forward <= ROTATION_RESET;
      step_scale       <= STEP_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DRIVE_POWER:      drive_power      <= cfg_data[7:0];
        REG_ROTATION_FORWARD: rotation_forward <= cfg_data[0];
        REG_STEP_SCALE:       step_scale       <= cfg_data;
        default:              ;   // unknown index, write dropped
      endcase
    end
  end

  // next step from the control word's jump field
  always_comb begin
    step_next = step + step_t'(1);
    case (uw.jmp)
      JMP_NEXT:     step_next = step + step_t'(1);
      JMP_WAIT_IN:  step_next = in_xfer ? step + step_t'(1) : step;
      JMP_LOOP:     step_next = (ph != 2'd2) ? uw.target : step + step_t'(1);
      JMP_WAIT_OUT: step_next = out_free ? uw.target : step;
      default:      step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // rom address: roll sample first, then the electrical angle per phase
  always_comb begin
    case (ph)
      2'd1:    phase_off = THIRD_TURN;
      2'd2:    phase_off = TWO_THIRD_TURN;
      default: phase_off = 16'd0;
    endcase
  end

  assign rom_bam  = (uw.op == OP_ROLL) ? roll : ea + phase_off;
  assign rom_prod = PW'(rom_bam) * PW'(SINE_TABLE_DEPTH);
  assign rom_idx  = rom_prod[16 +: IW];

  always_ff @(posedge clk) begin
    sin_q <= sine_rom[rom_idx];
  end

  // roll magnitude, -pi counts as pi
  assign mag = roll[15] ? 17'd65536 - {1'b0, roll} : {1'b0, roll};
  assign pct = (drive_power > FULL_POWER) ? FULL_POWER[6:0] : drive_power[6:0];

  // speed and update period from |sin roll|
  assign three_s = {1'b0, s, 1'b0} + {2'b00, s};
  assign speed   = big ? 3'd4 : 3'd1 + {1'b0, three_s[16:15]};
  assign period  = 3'd5 - speed;
  assign pc_inc  = pc + 3'd1;

  // angle step, only the low 16 bits matter modulo a turn
  assign step_amt = big ? {step_scale[14:0], 1'b0} : prod[30:15];
  assign add      = (!neg) == rotation_forward;

  assign cmd_full = quo >> RECIP_SHIFT;
  assign cmd_sat  = (cmd_full > QW'(COMMAND_SAT)) ? COMMAND_SAT : cmd_full[13:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ea <= 16'd0;
      pc <= 3'd0;
      ph <= 2'd0;
    end else begin
      case (uw.op)
        OP_ROLL:   ph <= 2'd0;
        OP_UPDATE: begin
          if (pc == 3'd0 && move) begin
            ea <= add ? ea + step_amt : ea - step_amt;
          end
          pc <= (pc_inc >= period) ? 3'd0 : pc_inc;
        end
        OP_STORE:  ph <= ph + 2'd1;
        default:   ;
      endcase
    end
  end

  // datapath payload registers
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_IDLE: begin
        if (in_xfer) begin
          roll <= s_tdata;
        end
      end
      OP_ROLL: begin
        neg  <= roll[15];
        big  <= (mag >= QUARTER_TURN);
        move <= (mag > ONE_DEGREE);
        k    <= KW'(MAX_COMMAND) * KW'(pct);
      end
      OP_ABS:     s    <= sin_q[15] ? 15'(-sin_q) : sin_q[14:0];
      OP_STEPMUL: prod <= 32'({step_scale, 1'b0}) * 32'(s);
      // 32768 plus sine as offset binary
      OP_MULA:    num  <= NW'(k) * NW'({~sin_q[15], sin_q[14:0]});
      OP_MULB:    quo  <= QW'(num[NW-1:16]) * QW'(RECIP_100);
      OP_STORE: begin
        case (ph)
          2'd0:    cmd_a <= cmd_sat;
          2'd1:    cmd_b <= cmd_sat;
          default: cmd_c <= cmd_sat;
        endcase
      end
      // output register loads only once the previous result is gone
      OP_OUTPUT: begin
        if (out_free) begin
          m_tdata <= {6'd0, cmd_c, cmd_b, cmd_a};
        end
      end
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (uw.op == OP_OUTPUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  // the last step with room in the output register always raises valid
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_OUTPUT && out_free) |=> m_tvalid)
    else $error("result not loaded into output register");

  // the update counter never passes the longest period
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc < 3'd4)
    else $error("period counter out of range");

  // the electrical angle moves only in the update step
  a_ea_hold: assert property (@(posedge clk) disable iff (rst)
    (uw.op != OP_UPDATE) |=> $stable(ea))
    else $error("electrical angle changed outside update step");

  // the step counter stays inside the program
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_OUTPUT)
    else $error("sequencer left the program");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_gimbal_roll_sine_commutation_unit.sv -----
// self-checking testbench for the gimbal roll sine commutation unit
// predicts the three pwm commands per roll sample and checks every output transfer
// depends on grsc_pkg for register indexes and angle constants
`timescale 1ns / 100ps

module tb_gimbal_roll_sine_commutation_unit;
  import grsc_pkg::*;

  localparam int unsigned MAX_CMD   = 9600;
  localparam int unsigned TAB_DEPTH = 256;
  // cycles from a sample transfer to its result, with margin
  localparam int unsigned LATENCY   = 18;
  localparam logic [1:0]  REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [13:0] a;
    logic [13:0] b;
    logic [13:0] c;
  } phase_cmd_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_CHOPPY,
    SINK_BURSTY
  } sink_mode_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] roll_angle
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;   // [13:0] phase_a, [27:14] phase_b, [41:28] phase_c, [47:42] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  gimbal_roll_sine_commutation_unit #(
    .MAX_COMMAND      (MAX_CMD),
    .SINE_TABLE_DEPTH (TAB_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // commutation model: registers and state as the block should hold them
  logic [7:0]  power_pct_reg;
  logic        forward_reg;
  logic [15:0] step_scale_reg;
  logic [15:0] elec_angle;
  logic [2:0]  update_count;
  logic signed [15:0] q15_sine [TAB_DEPTH];

  phase_cmd_t  pending_cmds[$];
  phase_cmd_t  cmd_head;

  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned results_ok  = 0;
  int unsigned reg_writes  = 0;

  sink_mode_e  sink_mode  = SINK_ALWAYS;
  int unsigned stall_left = 0;

  // q15 sine by a taylor series over the first quadrant, mirrored for the others
  function automatic logic signed [15:0] taylor_q15(input logic [15:0] bam);
    logic [63:0]        frac;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        q;
    longint             acc;
    logic signed [15:0] mag16;
    frac = {50'd0, bam[13:0]};
    if (bam[14]) begin
      frac = 64'd16384 - frac;
    end
    x    = (frac * HALF_PI_Q30) >> 14;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = (64'(acc) + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    mag16 = q[15:0];
    return bam[15] ? -mag16 : mag16;
  endfunction

  function automatic logic signed [15:0] sine_lookup(input logic [15:0] bam);
    longint unsigned idx;
    idx = (64'(bam) * 64'(TAB_DEPTH)) >> 16;
    if (idx >= TAB_DEPTH) begin
      idx = TAB_DEPTH - 1;
    end
    return q15_sine[idx];
  endfunction

  function automatic logic [13:0] pwm_command(input int unsigned pct, input logic [15:0] bam);
    longint unsigned num;
    longint unsigned v;
    num = 64'(MAX_CMD) * 64'(pct) * 64'(32768 + int'(sine_lookup(bam)));
    v   = num / 64'd6553600;
    if (v > 64'(COMMAND_SAT)) begin
      return COMMAND_SAT;
    end
    return v[13:0];
  endfunction

  // one control tick: maybe step the electrical angle, then the three commands
  function automatic phase_cmd_t advance_commutation(input logic [15:0] roll);
    logic               neg;
    logic [16:0]        mag;
    logic signed [15:0] sv;
    logic [15:0]        s;
    logic               big;
    logic [2:0]         period;
    logic [16:0]        step;
    int unsigned        pct;
    phase_cmd_t         r;
    neg    = roll[15];
    mag    = neg ? 17'd65536 - {1'b0, roll} : {1'b0, roll};
    sv     = sine_lookup(roll);
    s      = (sv < 0) ? 16'(-sv) : 16'(sv);
    big    = (mag >= QUARTER_TURN);
    // period is 5 - speed, speed 4 past a quarter turn
    period = big ? 3'd1 : 3'd4 - 3'((3 * int'(s)) >> 15);
    pct    = (power_pct_reg > FULL_POWER) ? FULL_POWER : power_pct_reg;
    if (update_count == 3'd0 && mag > ONE_DEGREE) begin
      step = big ? {step_scale_reg, 1'b0} : 17'((64'(step_scale_reg) * 64'd2 * 64'(s)) >> 15);
      if ((!neg) == forward_reg) begin
        elec_angle = elec_angle + step[15:0];
      end else begin
        elec_angle = elec_angle - step[15:0];
      end
    end
    update_count = update_count + 3'd1;
    if (update_count >= period) begin
      update_count = 3'd0;
    end
    r.a = pwm_command(pct, elec_angle);
    r.b = pwm_command(pct, elec_angle + THIRD_TURN);
    r.c = pwm_command(pct, elec_angle + TWO_THIRD_TURN);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // output side: every transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with nothing pending, phase_a", m_tdata[13:0], 0);
      end else begin
        cmd_head = pending_cmds.pop_front();
        if (m_tdata[13:0] !== cmd_head.a) begin
          report_mismatch("phase_a", m_tdata[13:0], cmd_head.a);
        end else if (m_tdata[27:14] !== cmd_head.b) begin
          report_mismatch("phase_b", m_tdata[27:14], cmd_head.b);
        end else if (m_tdata[41:28] !== cmd_head.c) begin
          report_mismatch("phase_c", m_tdata[41:28], cmd_head.c);
        end else if (m_tdata[47:42] !== 6'd0) begin
          report_mismatch("pad bits", m_tdata[47:42], 0);
        end else begin
          results_ok++;
        end
      end
    end
  end

  // receiver stall pattern, independent of the sender
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (sink_mode)
        SINK_ALWAYS: begin
          m_tready <= 1'b1;
        end
        SINK_CHOPPY: begin
          m_tready <= ($urandom_range(0, 99) >= 35);
        end
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(4, 40);
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // one roll sample transfer; valid stays high afterwards for back-to-back samples
  task automatic send_roll(input logic [15:0] roll);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= roll;
    do @(posedge clk); while (!s_tready);
    pending_cmds.push_back(advance_commutation(roll));
    items_sent++;
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n != 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 16'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold the sender until every pending command has come out
  task automatic wait_drained();
    idle_gap(1);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DRIVE_POWER:      power_pct_reg  = data[7:0];
      REG_ROTATION_FORWARD: forward_reg    = data[0];
      REG_STEP_SCALE:       step_scale_reg = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // roll values weighted toward the thresholds and the extremes
  function automatic logic [15:0] pick_roll();
    logic [15:0] mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom);
      5: mag = 16'($urandom_range(178, 188));
      6: mag = 16'($urandom_range(16378, 16390));
      7: mag = 16'($urandom_range(0, 600));
      8: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      default: mag = 16'($urandom_range(0, 16383));
    endcase
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  // reset register values, threshold and quadrant edges
  task automatic test_default_registers();
    send_roll(16'd0);
    send_roll(16'd1);
    send_roll(16'd182);
    send_roll(16'd183);
    send_roll(-16'd182);
    send_roll(-16'd183);
    send_roll(16'd16383);
    send_roll(16'd16384);
    send_roll(-16'd16384);
    send_roll(16'h7fff);
    send_roll(16'h8000);
  endtask

  // power above hundred, zero power, reversed direction, step scale extremes,
  // and a write to an index with no register behind it
  task automatic test_register_extremes();
    wait_drained();
    write_reg(REG_DRIVE_POWER, 16'hff_ff);
    write_reg(REG_ROTATION_FORWARD, 16'hfffe);
    write_reg(REG_STEP_SCALE, 16'hffff);
    send_roll(16'd16384);
    send_roll(16'h8000);
    send_roll(16'd8000);
    send_roll(-16'd8000);
    wait_drained();
    write_reg(REG_DRIVE_POWER, 16'hff00);
    write_reg(REG_STEP_SCALE, 16'h0000);
    send_roll(16'd20000);
    send_roll(16'd300);
    wait_drained();
    write_reg(REG_DRIVE_POWER, 16'd100);
    write_reg(REG_ROTATION_FORWARD, 16'h0001);
    write_reg(REG_STEP_SCALE, 16'hffff);
    send_roll(16'd5000);
    wait_drained();
    write_reg(REG_UNUSED, 16'hffff);
    write_reg(REG_DRIVE_POWER, 16'd101);
    send_roll(16'd16384);
  endtask

  // counter ramps on a long period, then a big roll shortens the period under it
  task automatic test_period_shrink();
    wait_drained();
    send_roll(16'd200);
    send_roll(16'd200);
    send_roll(16'd200);
    send_roll(16'd16384);
    send_roll(16'd200);
  endtask

  // random phases: fresh register settings, sink pattern and burst shape each time
  task automatic test_random_phases();
    int unsigned burst;
    int unsigned gap_max;
    int unsigned left;
    for (int ph = 0; ph < 12; ph++) begin
      wait_drained();
      case ($urandom_range(0, 4))
        0: write_reg(REG_DRIVE_POWER, {8'($urandom), 8'd0});
        1: write_reg(REG_DRIVE_POWER, {8'($urandom), 8'd100});
        2: write_reg(REG_DRIVE_POWER, {8'($urandom), 8'd255});
        3: write_reg(REG_DRIVE_POWER, {8'($urandom), 8'd101});
        default: write_reg(REG_DRIVE_POWER, 16'($urandom));
      endcase
      write_reg(REG_ROTATION_FORWARD, 16'($urandom));
      case ($urandom_range(0, 3))
        0: write_reg(REG_STEP_SCALE, 16'd0);
        1: write_reg(REG_STEP_SCALE, 16'hffff);
        2: write_reg(REG_STEP_SCALE, 16'($urandom_range(0, 2000)));
        default: write_reg(REG_STEP_SCALE, 16'($urandom));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, 16'($urandom));
      end
      sink_mode = sink_mode_e'(ph % 3);
      // every third phase streams with no sender gaps
      gap_max   = (ph % 3 == 0) ? 0 : $urandom_range(1, 10);
      left      = 162;
      while (left != 0) begin
        burst = $urandom_range(1, 16);
        if (burst > left) begin
          burst = left;
        end
        repeat (burst) send_roll(pick_roll());
        left = left - burst;
        idle_gap($urandom_range(0, gap_max));
      end
    end
    sink_mode = SINK_ALWAYS;
  endtask

  initial begin
    for (int i = 0; i < TAB_DEPTH; i++) begin
      q15_sine[i] = taylor_q15(16'((64'(i) * 64'd65536) / 64'(TAB_DEPTH)));
    end
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 16'd0;
    cfg_valid = 1'b0;
    cfg_index = REG_DRIVE_POWER;
    cfg_data  = 16'd0;
    power_pct_reg  = DRIVE_POWER_RESET;
    forward_reg    = ROTATION_RESET;
    step_scale_reg = STEP_SCALE_RESET;
    elec_angle     = 16'd0;
    update_count   = 3'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_registers();
    test_register_extremes();
    test_period_shrink();
    test_random_phases();

    idle_gap(1);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY * 2) @(posedge clk);

    $display("run covered %0d roll samples, %0d matching results, %0d register writes",
             items_sent, results_ok, reg_writes);
    $display("settings spanned power 0 to 255, both directions, step scale 0 to 65535");
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d results pending", pending_cmds.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
design/grsc_pkg.sv
design/gimbal_roll_sine_commutation_unit.sv
tb/tb_gimbal_roll_sine_commutation_unit.sv
